// ===== hw/rtl/pai_pkg.sv =====
// Package for the positional array block: sizes, field widths, codes and the
// control struct that drives the row of cells. No dependencies.
package pai_pkg;

  // Capacity of the array (2..64).
  localparam int DEPTH = 64;
  // Cell address width and live-count width.
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  // Fixed field widths of the item ports.
  localparam int KIND_W = 2;
  localparam int POS_W  = 7;
  localparam int DATA_W = 32;
  localparam int STAT_W = 3;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_DISPLAY = 2'd0,
    KIND_INSERT  = 2'd1,
    KIND_DELETE  = 2'd2,
    KIND_SEARCH  = 2'd3
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_BADPOS   = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } ctrl_state_e;

  // Broadcast to every cell each cycle.
  typedef struct packed {
    cell_op_e              op;
    logic [POS_W-1:0]      pos;
    logic [NW-1:0]         cnt;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/pai_cell.sv =====
// One storage cell of the array row: holds an entry and takes data from its
// left or right neighbor, the new value or the row head. Uses pai_pkg.
module pai_cell (
  input  logic                                clk_i,
  input  pai_pkg::cell_ctrl_t                 ctrl_i,
  input  logic [pai_pkg::AW-1:0]              idx_i,
  input  logic signed [pai_pkg::DATA_W-1:0]   value_i,
  input  logic signed [pai_pkg::DATA_W-1:0]   left_i,
  input  logic signed [pai_pkg::DATA_W-1:0]   right_i,
  input  logic signed [pai_pkg::DATA_W-1:0]   head_i,
  output logic signed [pai_pkg::DATA_W-1:0]   data_o
);
  import pai_pkg::*;

  logic signed [DATA_W-1:0] data_q, data_d;
  logic [POS_W-1:0]         idx_pos;
  logic [NW-1:0]            idx_nxt;

  assign idx_pos = POS_W'(idx_i);
  assign idx_nxt = NW'(idx_i) + 1'b1;

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (idx_pos == ctrl_i.pos) begin
          data_d = value_i;
        end else if (idx_pos > ctrl_i.pos) begin
          data_d = left_i;
        end
      end
      CELL_DELETE: begin
        if (idx_pos >= ctrl_i.pos) begin
          data_d = right_i;
        end
      end
      CELL_ROTATE: begin
        // rotate the live part left by one; last live cell takes the head
        if (idx_nxt == ctrl_i.cnt) begin
          data_d = head_i;
        end else if (idx_nxt < ctrl_i.cnt) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== hw/rtl/pai_chain.sv =====
// Row of DEPTH cells wired to their neighbors; exposes the head entry.
// Uses pai_pkg and pai_cell.
module pai_chain (
  input  logic                                clk_i,
  input  pai_pkg::cell_ctrl_t                 ctrl_i,
  input  logic signed [pai_pkg::DATA_W-1:0]   value_i,
  output logic signed [pai_pkg::DATA_W-1:0]   head_o
);
  import pai_pkg::*;

  logic signed [DATA_W-1:0] data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left, right;

    if (i == 0) begin : g_first
      assign left = value_i;
    end else begin : g_mid_l
      assign left = data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = data[0];
    end else begin : g_mid_r
      assign right = data[i+1];
    end

    pai_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .idx_i   (AW'(i)),
      .value_i (value_i),
      .left_i  (left),
      .right_i (right),
      .head_i  (data[0]),
      .data_o  (data[i])
    );
  end

  assign head_o = data[0];

endmodule

// ===== hw/rtl/positional_array_insert_delete_search_core.sv =====
// Positional array with insert, delete, linear search and display.
// Top level: control FSM and output register around pai_chain. Uses pai_pkg.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i/in_ready_o, kind, position,    | into core
//           | value                                     |
//   out     | out_valid_o/out_ready_i, status, index,   | out of core
//           | element, count, last                      |
//
// Insert, delete and every refused or empty request complete in the accept
// cycle: the chain shifts and the result lands in the output register.
// Display and search rotate the live entries through cell 0, one step per
// cycle after the accept cycle while the output register is free, and
// block the input until the final step (display yields one item per step,
// search one item at the final step); rotation restores the original order.
// Output stalls freeze the rotation. A new item is taken only when idle and
// the output register is free or being drained.
// Reset clears the count, FSM and output valid; cell contents are not reset.
module positional_array_insert_delete_search_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [pai_pkg::KIND_W-1:0]          kind_i,
  input  logic [pai_pkg::POS_W-1:0]           position_i,
  input  logic signed [pai_pkg::DATA_W-1:0]   value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [pai_pkg::STAT_W-1:0]          status_o,
  output logic [pai_pkg::IDX_W-1:0]           index_o,
  output logic signed [pai_pkg::DATA_W-1:0]   element_o,
  output logic [pai_pkg::CNT_W-1:0]           count_o,
  output logic                                last_o
);
  import pai_pkg::*;

  ctrl_state_e state_q, state_d;

  // live count and scan bookkeeping
  logic [NW-1:0]            cnt_q, cnt_d;
  logic [AW-1:0]            step_q, step_d;
  kind_e                    kind_q, kind_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic                     found_q, found_d;
  logic [AW-1:0]            fidx_q, fidx_d;

  // output register
  logic                     ovld_q, ovld_d;
  status_e                  ostat_q, ostat_d;
  logic [IDX_W-1:0]         oidx_q, oidx_d;
  logic signed [DATA_W-1:0] oelem_q, oelem_d;
  logic [CNT_W-1:0]         ocnt_q, ocnt_d;
  logic                     olast_q, olast_d;

  cell_ctrl_t               ctrl;
  logic signed [DATA_W-1:0] head;
  logic                     out_free, in_fire, adv, last_step, hit_now;
  kind_e                    kind_in;
  logic [POS_W-1:0]         cnt_pos;

  assign kind_in   = kind_e'(kind_i);
  assign cnt_pos   = POS_W'(cnt_q);
  assign out_free  = !ovld_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire   = in_valid_i && in_ready_o;
  assign adv       = (state_q == ST_SCAN) && out_free;
  assign last_step = (NW'(step_q) + 1'b1) == cnt_q;
  assign hit_now   = (head == val_q);

  pai_chain u_chain (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .value_i (value_i),
    .head_o  (head)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (kind_in == KIND_DISPLAY || kind_in == KIND_SEARCH) &&
            cnt_q != '0) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (adv && last_step) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control and output register loading
  always_comb begin
    ctrl.op  = CELL_HOLD;
    ctrl.pos = position_i;
    ctrl.cnt = cnt_q;
    cnt_d    = cnt_q;
    step_d   = step_q;
    kind_d   = kind_q;
    val_d    = val_q;
    found_d  = found_q;
    fidx_d   = fidx_q;
    ovld_d   = ovld_q && !out_ready_i;
    ostat_d  = ostat_q;
    oidx_d   = oidx_q;
    oelem_d  = oelem_q;
    ocnt_d   = ocnt_q;
    olast_d  = olast_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          kind_d  = kind_in;
          val_d   = value_i;
          step_d  = '0;
          found_d = 1'b0;
          oidx_d  = '0;
          oelem_d = '0;
          olast_d = 1'b1;
          ocnt_d  = CNT_W'(cnt_q);
          case (kind_in)
            KIND_INSERT: begin
              ovld_d = 1'b1;
              if (cnt_q == NW'(DEPTH)) begin
                ostat_d = STAT_FULL;
              end else if (position_i > cnt_pos) begin
                ostat_d = STAT_BADPOS;
              end else begin
                ctrl.op = CELL_INSERT;
                cnt_d   = cnt_q + 1'b1;
                ocnt_d  = CNT_W'(cnt_q + 1'b1);
                ostat_d = STAT_OK;
              end
            end
            KIND_DELETE: begin
              ovld_d = 1'b1;
              if (cnt_q == '0) begin
                ostat_d = STAT_EMPTY;
              end else if (position_i >= cnt_pos) begin
                ostat_d = STAT_BADPOS;
              end else begin
                ctrl.op = CELL_DELETE;
                cnt_d   = cnt_q - 1'b1;
                ocnt_d  = CNT_W'(cnt_q - 1'b1);
                ostat_d = STAT_OK;
              end
            end
            KIND_DISPLAY: begin
              if (cnt_q == '0) begin
                ovld_d  = 1'b1;
                ostat_d = STAT_EMPTY;
              end
            end
            default: begin
              if (cnt_q == '0) begin
                ovld_d  = 1'b1;
                ostat_d = STAT_NOTFOUND;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (adv) begin
          ctrl.op = CELL_ROTATE;
          step_d  = step_q + 1'b1;
          ocnt_d  = CNT_W'(cnt_q);
          if (kind_q == KIND_DISPLAY) begin
            ovld_d  = 1'b1;
            ostat_d = STAT_OK;
            oidx_d  = IDX_W'(step_q);
            oelem_d = head;
            olast_d = last_step;
          end else begin
            if (hit_now && !found_q) begin
              found_d = 1'b1;
              fidx_d  = step_q;
            end
            if (last_step) begin
              ovld_d  = 1'b1;
              olast_d = 1'b1;
              oelem_d = '0;
              if (found_q) begin
                ostat_d = STAT_OK;
                oidx_d  = IDX_W'(fidx_q);
              end else if (hit_now) begin
                ostat_d = STAT_OK;
                oidx_d  = IDX_W'(step_q);
              end else begin
                ostat_d = STAT_NOTFOUND;
                oidx_d  = '0;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
      step_q  <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovld_q  <= ovld_d;
      step_q  <= step_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    val_q   <= val_d;
    fidx_q  <= fidx_d;
    ostat_q <= ostat_d;
    oidx_q  <= oidx_d;
    oelem_q <= oelem_d;
    ocnt_q  <= ocnt_d;
    olast_q <= olast_d;
  end

  assign out_valid_o = ovld_q;
  assign status_o    = ostat_q;
  assign index_o     = oidx_q;
  assign element_o   = oelem_q;
  assign count_o     = ocnt_q;
  assign last_o      = olast_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(DEPTH))
    else $error("live count above capacity");

  a_scan_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !in_ready_o)
    else $error("input accepted during a scan");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && kind_in == KIND_INSERT && cnt_q != NW'(DEPTH) &&
     position_i <= cnt_pos) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("accepted insert did not grow the count");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && last_step) |=> (state_q == ST_IDLE && ovld_q && olast_q))
    else $error("final scan step did not deliver a last item");

  a_scan_keeps_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |=> $stable(cnt_q))
    else $error("count changed during a scan");
`endif

endmodule
